@@ hdl/mlcc_pkg.sv @@
// Shared types and constants for the MOSI line coherence controller.
// No dependencies; imported by the controller and its checker.
`timescale 1ns / 1ps
package mlcc_pkg;

  localparam int ADDR_BITS = 32;
  localparam int ADDR_W    = 32;
  localparam int REQ_ID_W  = 4;

  localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                            : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [2:0] {
    ST_I  = 3'd0,
    ST_S  = 3'd1,
    ST_O  = 3'd2,
    ST_M  = 3'd3,
    ST_IE = 3'd4,
    ST_IM = 3'd5,
    ST_SM = 3'd6,
    ST_FM = 3'd7
  } line_state_t;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_STORE = 3'd1,
    OP_GETS  = 3'd2,
    OP_GETM  = 3'd3,
    OP_DATA  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_GETS = 2'd1,
    REQ_GETM = 2'd2
  } bus_req_t;

endpackage

@@ hdl/mosi_line_coherence_controller_unit.sv @@
// An input transfer passes through the input register and then the result register.
// Throughput: one event per cycle unless out_stall holds a result; line state updates
// as an event moves to the result register, so the following event always sees it.
// Reset (rst, synchronous, active high): line state goes to I, both stages empty.
// Depends on mlcc_pkg.
`timescale 1ns / 1ps
module mosi_line_coherence_controller_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   opcode,
  input  logic [mlcc_pkg::ADDR_W-1:0]  line_addr,
  input  logic [mlcc_pkg::REQ_ID_W-1:0] requester,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   bus_request,
  output logic [mlcc_pkg::ADDR_W-1:0]  out_addr,
  output logic                         data_to_proc,
  output logic                         data_on_bus,
  output logic [mlcc_pkg::REQ_ID_W-1:0] data_dest,
  output logic                         shared_assert,
  output logic                         miss,
  output logic                         protocol_error,
  output logic [2:0]                   new_state
);
  import mlcc_pkg::*;

  // input stage
  logic                s1_valid;
  logic [2:0]          s1_opcode;
  logic [ADDR_W-1:0]   s1_addr;
  logic [REQ_ID_W-1:0] s1_req;

  line_state_t line_state;
  line_state_t line_state_next;

  logic     out_ok;
  logic     advance;
  logic     err;
  bus_req_t breq;
  logic     to_proc;
  logic     on_bus;
  logic     shared;
  logic     miss_c;
  logic     send_addr;

  assign out_ok   = !out_valid || !out_stall;
  assign advance  = s1_valid && out_ok;
  assign in_stall = s1_valid && !out_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_opcode <= opcode;
      s1_addr   <= line_addr & ADDR_MASK;
      s1_req    <= requester;
    end
  end

  // illegal events
  always_comb begin
    case (s1_opcode)
      OP_LOAD, OP_STORE: err = (line_state inside {ST_IE, ST_IM, ST_SM, ST_FM});
      OP_GETS, OP_GETM:  err = 1'b0;
      OP_DATA:           err = (line_state inside {ST_S, ST_O, ST_M});
      default:           err = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    line_state_next = line_state;
    if (!err) begin
      case (s1_opcode)
        OP_LOAD: begin
          if (line_state == ST_I) line_state_next = ST_IE;
        end
        OP_STORE: begin
          case (line_state)
            ST_I:    line_state_next = ST_IM;
            ST_S:    line_state_next = ST_SM;
            ST_O:    line_state_next = ST_FM;
            default: line_state_next = line_state;
          endcase
        end
        OP_GETS: begin
          if (line_state == ST_M) line_state_next = ST_O;
        end
        OP_GETM: begin
          case (line_state)
            ST_S, ST_O, ST_M: line_state_next = ST_I;
            ST_SM, ST_FM:     line_state_next = ST_IM;
            default:          line_state_next = line_state;
          endcase
        end
        OP_DATA: begin
          case (line_state)
            ST_IE:               line_state_next = ST_S;
            ST_IM, ST_SM, ST_FM: line_state_next = ST_M;
            default:             line_state_next = line_state;
          endcase
        end
        default: line_state_next = line_state;
      endcase
    end
  end

  // actions
  always_comb begin
    breq    = REQ_NONE;
    to_proc = 1'b0;
    on_bus  = 1'b0;
    shared  = 1'b0;
    miss_c  = 1'b0;
    if (!err) begin
      case (s1_opcode)
        OP_LOAD: begin
          if (line_state == ST_I) begin
            breq   = REQ_GETS;
            miss_c = 1'b1;
          end else begin
            to_proc = 1'b1;
          end
        end
        OP_STORE: begin
          if (line_state == ST_M) begin
            to_proc = 1'b1;
          end else begin
            breq   = REQ_GETM;
            miss_c = 1'b1;
          end
        end
        OP_GETS, OP_GETM: begin
          shared = (line_state inside {ST_S, ST_O, ST_M, ST_SM, ST_FM});
          on_bus = (line_state inside {ST_O, ST_M, ST_FM});
        end
        OP_DATA: begin
          to_proc = (line_state != ST_I);
        end
        default: begin
          breq = REQ_NONE;
        end
      endcase
    end
  end

  assign send_addr = (breq != REQ_NONE) || to_proc || on_bus;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_state <= ST_I;
      out_valid  <= 1'b0;
    end else begin
      if (advance) line_state <= line_state_next;
      if (out_ok) out_valid <= s1_valid;
    end
    if (advance) begin
      bus_request    <= breq;
      out_addr       <= send_addr ? s1_addr : '0;
      data_to_proc   <= to_proc;
      data_on_bus    <= on_bus;
      data_dest      <= on_bus ? s1_req : '0;
      shared_assert  <= shared;
      miss           <= miss_c;
      protocol_error <= err;
      new_state      <= line_state_next;
    end
  end

endmodule

@@ hdl/mlcc_checker.sv @@
// Port-level checks for the MOSI line coherence controller, bound to the top level.
// Depends on mlcc_pkg and mosi_line_coherence_controller_unit.
`timescale 1ns / 1ps
module mlcc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   bus_request,
  input logic [mlcc_pkg::ADDR_W-1:0]  out_addr,
  input logic                         data_to_proc,
  input logic                         data_on_bus,
  input logic                         shared_assert,
  input logic                         miss,
  input logic                         protocol_error,
  input logic [2:0]                   new_state
);
  import mlcc_pkg::*;

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(new_state) && $stable(out_addr)
      && $stable(bus_request))
    else $error("result changed while stalled");

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && protocol_error |-> bus_request == REQ_NONE && !data_to_proc
      && !data_on_bus && !shared_assert && !miss)
    else $error("illegal event produced an action");

  a_miss_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && miss |-> bus_request == REQ_GETS || bus_request == REQ_GETM)
    else $error("miss without bus request");

  a_supply_shared: assert property (@(posedge clk) disable iff (rst)
    out_valid && data_on_bus |-> shared_assert)
    else $error("data supplied without shared assertion");

  a_gets_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && bus_request == REQ_GETS |-> new_state == ST_IE)
    else $error("GETS issued without entering IE");

endmodule

bind mosi_line_coherence_controller_unit mlcc_checker u_mlcc_checker (.*);
